[rtl/petc_pkg.sv]
package petc_pkg;

    localparam int          CFG_WIDTH       = 20;
    localparam logic [19:0] MAX_STEPS_RESET = 20'd1000000;

    localparam int          EDGE_CNT_WIDTH = 4;
    localparam logic [3:0]  EDGE_LIMIT     = 4'd9;
    localparam logic [3:0]  EDGE_IDX_E1    = 4'd1;  // first edge of the low-phase measured window
    localparam logic [3:0]  EDGE_IDX_E2    = 4'd2;  // edge whose level picks the phase
    localparam logic [3:0]  EDGE_IDX_LAST  = 4'd8;  // last edge of the run, results derived here

    localparam int          QUEUE_DEPTH = 2;

    typedef enum logic {
        KIND_STEP    = 1'b0,
        KIND_RESTART = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind kind;
        logic  level;
    } t_item;

    // status of one item as it travels down the back end
    typedef struct packed {
        logic       valid;
        logic       restart;
        logic       derive;
        logic       done;
        logic       timed_out;
        logic [3:0] edges;
        logic       center;
    } t_status;

endpackage

[rtl/petc_front.sv]
module petc_front import petc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  logic  i_restart,
    input  logic  i_prox_level,
    output logic  o_push,
    output t_item o_item,
    input  logic  i_q_ready
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign o_ready = !r_valid || i_q_ready;
    assign o_push  = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item.kind  = i_restart ? KIND_RESTART : KIND_STEP;
        n_item.level = i_prox_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

[rtl/petc_queue.sv]
module petc_queue import petc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_ready,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign wr_en   = i_push && o_ready;
    assign rd_en   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_en) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

[rtl/petc_track.sv]
module petc_track import petc_pkg::*; #(
    parameter int STEP_COUNT_WIDTH = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_q_valid,
    input  t_item                       i_q_item,
    output logic                        o_pop,
    input  logic [CFG_WIDTH-1:0]        i_max_steps,
    output t_status                     o_stat,
    output logic [STEP_COUNT_WIDTH-1:0] o_cyc_sum,
    output logic [STEP_COUNT_WIDTH-1:0] o_dwell_sum
);

    localparam int W  = STEP_COUNT_WIDTH;
    localparam int CW = (W > CFG_WIDTH) ? W : CFG_WIDTH;
    localparam logic [W-1:0] STEP_FULL = {W{1'b1}};

    logic                      r_last;
    logic [W-1:0]              r_step;
    logic [EDGE_CNT_WIDTH-1:0] r_cnt;
    logic                      r_third;
    logic                      r_fin;
    logic [W-1:0]              r_acc_even;  // spans ending on edges 2,4,6
    logic [W-1:0]              r_acc_odd;   // spans ending on edges 3,5,7
    logic [W-1:0]              r_e1;
    logic [W-1:0]              r_e2;
    logic [W-1:0]              r_eprev;

    logic                      n_last;
    logic [W-1:0]              n_step;
    logic [EDGE_CNT_WIDTH-1:0] n_cnt;
    logic                      n_third;
    logic                      n_fin;
    logic [W-1:0]              n_acc_even;
    logic [W-1:0]              n_acc_odd;
    logic [W-1:0]              n_e1;
    logic [W-1:0]              n_e2;
    logic [W-1:0]              n_eprev;

    t_status                   r_stat;
    t_status                   n_stat;
    logic [W-1:0]              r_cyc_sum;
    logic [W-1:0]              r_dwell_sum;
    logic [W-1:0]              n_cyc_sum;
    logic [W-1:0]              n_dwell_sum;

    logic [W-1:0]              span;
    logic                      cur_timed;
    logic                      derive;
    logic                      restart;
    logic [CW-1:0]             max_ext;

    assign o_pop       = i_en && i_q_valid;
    assign o_stat      = r_stat;
    assign o_cyc_sum   = r_cyc_sum;
    assign o_dwell_sum = r_dwell_sum;

    assign restart   = (i_q_item.kind == KIND_RESTART);
    assign max_ext   = CW'(i_max_steps);
    assign span      = r_step - r_eprev;
    assign cur_timed = !r_fin && ((CW'(r_step) >= max_ext) || (r_step == STEP_FULL));

    always_comb begin
        n_last      = r_last;
        n_step      = r_step;
        n_cnt       = r_cnt;
        n_third     = r_third;
        n_fin       = r_fin;
        n_acc_even  = r_acc_even;
        n_acc_odd   = r_acc_odd;
        n_e1        = r_e1;
        n_e2        = r_e2;
        n_eprev     = r_eprev;
        n_cyc_sum   = r_cyc_sum;
        n_dwell_sum = r_dwell_sum;
        derive      = 1'b0;

        if (o_pop) begin
            if (restart) begin
                n_last     = i_q_item.level;
                n_step     = '0;
                n_cnt      = '0;
                n_third    = 1'b0;
                n_fin      = 1'b0;
                n_acc_even = '0;
                n_acc_odd  = '0;
            end else if (!r_fin && !cur_timed) begin
                if ((i_q_item.level != r_last) && (r_cnt < EDGE_LIMIT)) begin
                    n_eprev = r_step;
                    n_cnt   = r_cnt + 1'b1;
                    if (r_cnt == EDGE_IDX_E1) begin
                        n_e1 = r_step;
                    end
                    if (r_cnt == EDGE_IDX_E2) begin
                        n_e2    = r_step;
                        n_third = i_q_item.level;
                    end
                    if ((r_cnt >= EDGE_IDX_E2) && (r_cnt < EDGE_IDX_LAST)) begin
                        if (r_cnt[0]) begin
                            n_acc_odd = r_acc_odd + span;
                        end else begin
                            n_acc_even = r_acc_even + span;
                        end
                    end
                    if (r_cnt == EDGE_IDX_LAST) begin
                        derive = 1'b1;
                        n_fin  = 1'b1;
                        // high phase: E8-E2 and even spans; low phase: E7-E1 and odd spans
                        n_cyc_sum   = r_third ? (r_step - r_e2) : (r_eprev - r_e1);
                        n_dwell_sum = r_third ? r_acc_even : r_acc_odd;
                    end
                end
                n_last = i_q_item.level;
                if (!n_fin && (r_step != STEP_FULL)) begin
                    n_step = r_step + 1'b1;
                end
            end
        end

        n_stat.valid     = o_pop;
        n_stat.restart   = restart;
        n_stat.derive    = derive;
        n_stat.done      = n_fin;
        n_stat.timed_out = !n_fin && ((CW'(n_step) >= max_ext) || (n_step == STEP_FULL));
        n_stat.edges     = n_cnt;
        n_stat.center    = n_third;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last     <= 1'b0;
            r_step     <= '0;
            r_cnt      <= '0;
            r_third    <= 1'b0;
            r_fin      <= 1'b0;
            r_acc_even <= '0;
            r_acc_odd  <= '0;
            r_stat     <= '0;
        end else if (i_en) begin
            r_last     <= n_last;
            r_step     <= n_step;
            r_cnt      <= n_cnt;
            r_third    <= n_third;
            r_fin      <= n_fin;
            r_acc_even <= n_acc_even;
            r_acc_odd  <= n_acc_odd;
            r_stat     <= n_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e1        <= n_e1;
            r_e2        <= n_e2;
            r_eprev     <= n_eprev;
            r_cyc_sum   <= n_cyc_sum;
            r_dwell_sum <= n_dwell_sum;
        end
    end

endmodule

[rtl/petc_calc.sv]
module petc_calc import petc_pkg::*; #(
    parameter int STEP_COUNT_WIDTH = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  t_status                     i_stat,
    input  logic [STEP_COUNT_WIDTH-1:0] i_cyc_sum,
    input  logic [STEP_COUNT_WIDTH-1:0] i_dwell_sum,
    output t_status                     o_stat,
    output logic [STEP_COUNT_WIDTH-1:0] o_cycle,
    output logic [STEP_COUNT_WIDTH-2:0] o_half_dwell
);

    localparam int W  = STEP_COUNT_WIDTH;
    localparam int PW = 2 * W + 1;
    localparam int SH = W + 2;
    // floor(2^(W+2)/3): estimate is exact or one low for any W-bit value
    localparam logic [W:0] RECIP = (W + 1)'((64'd1 << SH) / 64'd3);

    t_status       r2_stat;
    logic [PW-1:0] r2_prod_c;
    logic [PW-1:0] r2_prod_d;
    logic [2:0]    r2_xc;
    logic [2:0]    r2_xd;

    t_status       r3_stat;
    logic [W-1:0]  r_cycle;
    logic [W-2:0]  r_half;

    logic [W-2:0]  q0_c;
    logic [W-2:0]  q0_d;
    logic [2:0]    rem_c;
    logic [2:0]    rem_d;
    logic [W-2:0]  q_c;
    logic [W-2:0]  q_d;

    assign q0_c = r2_prod_c[PW-1:SH];
    assign q0_d = r2_prod_d[PW-1:SH];

    // only the low bits of x - 3*q0 matter, the remainder stays below 6
    assign rem_c = r2_xc - (q0_c[2:0] + {q0_c[1:0], 1'b0});
    assign rem_d = r2_xd - (q0_d[2:0] + {q0_d[1:0], 1'b0});
    assign q_c   = q0_c + (W - 1)'(rem_c >= 3'd3);
    assign q_d   = q0_d + (W - 1)'(rem_d >= 3'd3);

    assign o_stat       = r3_stat;
    assign o_cycle      = r_cycle;
    assign o_half_dwell = r_half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_stat <= '0;
            r3_stat <= '0;
            r_cycle <= '0;
            r_half  <= '0;
        end else if (i_en) begin
            r2_stat <= i_stat;
            r3_stat <= r2_stat;
            if (r2_stat.valid) begin
                if (r2_stat.restart) begin
                    r_cycle <= '0;
                    r_half  <= '0;
                end else if (r2_stat.derive) begin
                    r_cycle <= {1'b0, q_c};
                    r_half  <= {1'b0, q_d[W-2:1]};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_prod_c <= PW'(i_cyc_sum) * PW'(RECIP);
            r2_prod_d <= PW'(i_dwell_sum) * PW'(RECIP);
            r2_xc     <= i_cyc_sum[2:0];
            r2_xd     <= i_dwell_sum[2:0];
        end
    end

endmodule

[rtl/prox_edge_travel_calibrator.sv]
// Proximity-switch travel calibrator. Send one restart item to prime the switch level, then one
// item per motor step with the switch level sampled before that step; every item returns one
// status item. After nine level changes the result carries the average cycle length and half
// the average switch dwell (three periods, truncated), and the centering direction is the
// level after edge E2. Once the step count reaches max_steps, or the step counter
// saturates, timed_out is set and steps are ignored until a restart or a larger budget.
// Throughput is one item per clock while the output accepts results, set by the edge tracker
// that updates the run state; an accepted item passes the input register, the queue, the
// tracker, the reciprocal multiply and the output register before its result is valid. The
// user must write max_steps through its own port only while no items are in flight; the block
// itself does not enforce this. STEP_COUNT_WIDTH sets the step counter and result widths.
module prox_edge_travel_calibrator import petc_pkg::*; #(
    parameter int STEP_COUNT_WIDTH = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_restart,
    input  logic                        i_prox_level,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_done_res,
    output logic                        o_timed_out,
    output logic [EDGE_CNT_WIDTH-1:0]   o_edges_seen,
    output logic [STEP_COUNT_WIDTH-1:0] o_cycle_steps,
    output logic [STEP_COUNT_WIDTH-2:0] o_half_dwell_steps,
    output logic                        o_center_direction,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [CFG_WIDTH-1:0]        i_cfg_max_steps
);

    localparam int W = STEP_COUNT_WIDTH;

    logic [CFG_WIDTH-1:0] r_max_steps;

    logic    push;
    t_item   front_item;
    logic    q_ready;
    logic    q_valid;
    t_item   q_item;
    logic    pop;
    logic    en;
    t_status trk_stat;
    logic [W-1:0] cyc_sum;
    logic [W-1:0] dwell_sum;
    t_status out_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_steps <= MAX_STEPS_RESET;
        end else if (i_cfg_valid) begin
            r_max_steps <= i_cfg_max_steps;
        end
    end

    // back end moves as one unit, held only by a result waiting at the output
    assign en = !out_stat.valid || i_out_ready;

    petc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_restart    (i_restart),
        .i_prox_level (i_prox_level),
        .o_push       (push),
        .o_item       (front_item),
        .i_q_ready    (q_ready)
    );

    petc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    petc_track #(
        .STEP_COUNT_WIDTH (W)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_pop       (pop),
        .i_max_steps (r_max_steps),
        .o_stat      (trk_stat),
        .o_cyc_sum   (cyc_sum),
        .o_dwell_sum (dwell_sum)
    );

    petc_calc #(
        .STEP_COUNT_WIDTH (W)
    ) u_calc (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_stat       (trk_stat),
        .i_cyc_sum    (cyc_sum),
        .i_dwell_sum  (dwell_sum),
        .o_stat       (out_stat),
        .o_cycle      (o_cycle_steps),
        .o_half_dwell (o_half_dwell_steps)
    );

    assign o_out_valid        = out_stat.valid;
    assign o_done_res         = out_stat.done;
    assign o_timed_out        = out_stat.timed_out;
    assign o_edges_seen       = out_stat.edges;
    assign o_center_direction = out_stat.center;

endmodule

[test/calib_status_checker.sv]
module calib_status_checker
    import petc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic                  i_restart,
    input  logic                  i_prox_level,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_done_res,
    input  logic                  i_timed_out,
    input  logic [3:0]            i_edges_seen,
    input  logic [19:0]           i_cycle_steps,
    input  logic [18:0]           i_half_dwell_steps,
    input  logic                  i_center_direction,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_WIDTH-1:0]  i_cfg_max_steps,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STEP_W = 20;

    typedef logic [STEP_W-1:0] t_step;
    typedef logic [STEP_W+1:0] t_span_sum;

    typedef struct packed {
        logic                done;
        logic                timed_out;
        logic [3:0]          edges;
        t_step               cycle;
        logic [STEP_W-2:0]   half_dwell;
        logic                center;
    } t_calib_status;

    // mirror of the calibration run
    t_step             budget;
    t_step             step_idx;
    logic              last_lvl;
    logic [3:0]        edge_cnt;
    t_step             edge_pos [9];
    logic              center_lvl;
    logic              finished;
    t_step             cycle_avg;
    logic [STEP_W-2:0] half_dwell;

    t_calib_status status_q [$];

    function automatic void clear_run();
        last_lvl   = 1'b0;
        step_idx   = '0;
        edge_cnt   = '0;
        center_lvl = 1'b0;
        finished   = 1'b0;
        cycle_avg  = '0;
        half_dwell = '0;
    endfunction

    // a saturated step counter counts as spent too
    function automatic logic budget_spent();
        return !finished && (step_idx >= budget || step_idx == '1);
    endfunction

    function automatic t_step edge_gap(input int a, input int b);
        return edge_pos[b] - edge_pos[a];
    endfunction

    function automatic void derive_averages();
        t_span_sum cyc_sum;
        t_span_sum dwell_sum;
        t_span_sum dwell_avg;
        // the level after edge E2 picks which half-periods are dwell
        if (!center_lvl) begin
            cyc_sum   = edge_gap(1, 3) + edge_gap(3, 5) + edge_gap(5, 7);
            dwell_sum = edge_gap(2, 3) + edge_gap(4, 5) + edge_gap(6, 7);
        end else begin
            cyc_sum   = edge_gap(2, 4) + edge_gap(4, 6) + edge_gap(6, 8);
            dwell_sum = edge_gap(1, 2) + edge_gap(3, 4) + edge_gap(5, 6);
        end
        cycle_avg  = t_step'(cyc_sum / 3);
        dwell_avg  = t_span_sum'(dwell_sum / 3);
        half_dwell = dwell_avg[STEP_W-1:1];
        finished   = 1'b1;
    endfunction

    function automatic t_calib_status apply_item(input logic restart, input logic lvl);
        t_calib_status s;
        if (t_kind'(restart) == KIND_RESTART) begin
            clear_run();
            last_lvl = lvl;
        end else if (!finished && !budget_spent()) begin
            if (lvl != last_lvl && edge_cnt < EDGE_LIMIT) begin
                edge_pos[edge_cnt] = step_idx;
                if (edge_cnt == EDGE_IDX_E2) begin
                    center_lvl = lvl;
                end
                edge_cnt++;
                if (edge_cnt == EDGE_LIMIT) begin
                    derive_averages();
                end
            end
            last_lvl = lvl;
            if (!finished && step_idx != '1) begin
                step_idx++;
            end
        end
        s.done       = finished;
        s.timed_out  = budget_spent();
        s.edges      = edge_cnt;
        s.cycle      = cycle_avg;
        s.half_dwell = half_dwell;
        s.center     = center_lvl;
        return s;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_calib_status want;
        if (!i_rst_n) begin
            clear_run();
            budget = MAX_STEPS_RESET;
            status_q.delete();
            o_fail_count = 0;
        end else begin
            // compare before pushing: a result never belongs to the item accepted with it
            if (i_out_valid && i_out_ready) begin
                if (status_q.size() == 0) begin
                    $error("result item arrived with no expectation pending");
                    o_fail_count++;
                end else begin
                    want = status_q.pop_front();
                    check_field("done_res", want.done, i_done_res);
                    check_field("timed_out", want.timed_out, i_timed_out);
                    check_field("edges_seen", want.edges, i_edges_seen);
                    check_field("cycle_steps", want.cycle, i_cycle_steps);
                    check_field("half_dwell_steps", want.half_dwell, i_half_dwell_steps);
                    check_field("center_direction", want.center, i_center_direction);
                end
            end
            if (i_in_valid && i_in_ready) begin
                status_q.push_back(apply_item(i_restart, i_prox_level));
            end
            if (i_cfg_valid && i_cfg_ready) begin
                budget = i_cfg_max_steps;
            end
        end
        o_pending = status_q.size();
    end

endmodule

[test/testbench.sv]
module testbench import petc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [19:0] BUDGET_MAX  = 20'hFFFFF;
    localparam int          RAND_ITEMS  = 1900;
    localparam int          LONG_HOLD   = 400;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_restart    = 1'b0;
    logic        in_level      = 1'b0;
    logic        out_ready     = 1'b0;
    logic        cfg_valid     = 1'b0;
    logic [19:0] cfg_max_steps = '0;

    logic        in_ready;
    logic        out_valid;
    logic        done_res;
    logic        timed_out;
    logic [3:0]  edges_seen;
    logic [19:0] cycle_steps;
    logic [18:0] half_dwell_steps;
    logic        center_direction;
    logic        cfg_ready;

    int          fail_count;
    int          pending;
    int          items_sent = 0;
    logic        idle_on    = 1'b1;
    logic        hold_out   = 1'b0;

    always #4 clk = ~clk;

    prox_edge_travel_calibrator dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_restart          (in_restart),
        .i_prox_level       (in_level),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_done_res         (done_res),
        .o_timed_out        (timed_out),
        .o_edges_seen       (edges_seen),
        .o_cycle_steps      (cycle_steps),
        .o_half_dwell_steps (half_dwell_steps),
        .o_center_direction (center_direction),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_max_steps    (cfg_max_steps)
    );

    calib_status_checker checker_i (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_restart          (in_restart),
        .i_prox_level       (in_level),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_done_res         (done_res),
        .i_timed_out        (timed_out),
        .i_edges_seen       (edges_seen),
        .i_cycle_steps      (cycle_steps),
        .i_half_dwell_steps (half_dwell_steps),
        .i_center_direction (center_direction),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_max_steps    (cfg_max_steps),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    function automatic int pick_gap();
        int r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_dwell();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(13, 60);
        end
        return $urandom_range(1, 12);
    endfunction

    function automatic logic [19:0] pick_budget();
        case ($urandom_range(0, 9))
            0:       return 20'd1;
            1, 2, 3: return 20'($urandom_range(2, 60));
            4, 5:    return 20'($urandom_range(61, BUDGET_MAX - 1));
            6:       return BUDGET_MAX;
            7:       return MAX_STEPS_RESET;
            default: return 20'($urandom_range(200, 5000));
        endcase
    endfunction

    // small budgets time out quickly, so keep those phases short
    function automatic bit checker_budget_small();
        return cfg_max_steps < 20'd100;
    endfunction

    // ready is sampled at the falling edge; inputs only move at rising edges
    task automatic offer(input t_kind kind, input logic lvl);
        logic took;
        int   gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        in_restart <= kind;
        in_level   <= lvl;
        do begin
            @(negedge clk);
            took = in_ready;
            @(posedge clk);
        end while (!took);
        items_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
    endtask

    task automatic write_budget(input logic [19:0] value);
        logic took;
        drain_results();
        cfg_valid     <= 1'b1;
        cfg_max_steps <= value;
        do begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end while (!took);
        cfg_valid <= 1'b0;
    endtask

    // restart, then runs of equal levels; every run after the first starts with an edge
    task automatic play_runs(input logic first_lvl, input int runs [10]);
        logic lvl;
        lvl = first_lvl;
        offer(KIND_RESTART, first_lvl);
        for (int i = 0; i < 10; i++) begin
            repeat (runs[i]) offer(KIND_STEP, lvl);
            lvl = ~lvl;
        end
    endtask

    task automatic run_calibration();
        logic lvl;
        int   edges_wanted;
        int   tail;
        lvl = 1'($urandom_range(0, 1));
        // sometimes carry on from whatever state the block is in
        if ($urandom_range(0, 4) != 0) begin
            offer(KIND_RESTART, lvl);
        end
        edges_wanted = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8) : 9;
        for (int e = 0; e <= edges_wanted; e++) begin
            repeat ((e == 0) ? $urandom_range(0, 4) : pick_dwell()) begin
                if ($urandom_range(0, 199) == 0) begin
                    offer(t_kind'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end else begin
                    offer(KIND_STEP, lvl);
                end
            end
            lvl = ~lvl;
        end
        tail = $urandom_range(0, 4);
        repeat (tail) offer(KIND_STEP, 1'($urandom_range(0, 1)));
    endtask

    // receiver side
    initial begin
        int   run_left;
        logic rdy;
        run_left = 0;
        rdy      = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_out) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_out = 1'b0;
            end else if (!idle_on) begin
                out_ready <= 1'b1;
            end else begin
                if (run_left == 0) begin
                    rdy = $urandom_range(0, 99) < 65;
                    if (rdy) begin
                        run_left = $urandom_range(1, 20);
                    end else if ($urandom_range(0, 9) == 0) begin
                        run_left = $urandom_range(15, 50);
                    end else begin
                        run_left = $urandom_range(1, 3);
                    end
                end
                out_ready <= rdy;
                run_left--;
            end
        end
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int  seq_left;
        bit  hold_done;
        seq_left  = 0;
        hold_done = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: first run starts on an edge right away, high branch
        play_runs(1'b0, '{0, 1, 1, 1, 1, 1, 1, 1, 1, 1});
        // low branch, uneven dwell, then a level change after finish is held
        play_runs(1'b1, '{2, 1, 1, 2, 1, 1, 1, 1, 1, 1});
        offer(KIND_STEP, 1'b0);
        offer(KIND_STEP, 1'b1);

        // smallest budget: one step then timed out, a larger budget resumes
        write_budget(20'd1);
        offer(KIND_RESTART, 1'b0);
        offer(KIND_STEP, 1'b1);
        offer(KIND_STEP, 1'b0);
        write_budget(BUDGET_MAX);
        offer(KIND_STEP, 1'b0);
        offer(KIND_STEP, 1'b1);

        write_budget(MAX_STEPS_RESET);
        items_sent = 0;
        while (items_sent < RAND_ITEMS) begin
            if (seq_left == 0) begin
                write_budget(pick_budget());
                seq_left = (checker_budget_small()) ? 1 : 3;
            end
            idle_on = $urandom_range(0, 4) != 0;
            if (!hold_done && items_sent > 600) begin
                idle_on   = 1'b0;
                hold_out  = 1'b1;
                hold_done = 1'b1;
            end
            run_calibration();
            seq_left--;
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
